### src/tgad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA decoder package
// Shared types and constants for the front parser, command queue and back end.
// ----------------------------------------------------------------------------
package tgad_pkg;

    // Result kinds
    localparam logic [1:0] KIND_RUN      = 2'd0;
    localparam logic [1:0] KIND_EMPTY    = 2'd1;
    localparam logic [1:0] KIND_BAD_TYPE = 2'd2;
    localparam logic [1:0] KIND_BAD_FMT  = 2'd3;

    // Header byte offsets
    localparam logic [4:0] HDR_ID_LEN    = 5'd0;
    localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
    localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_BPP       = 5'd16;
    localparam logic [4:0] HDR_LAST      = 5'd17;

    // Header field values
    localparam logic [7:0] TGA_TYPE_RAW = 8'd2;
    localparam logic [7:0] TGA_TYPE_RLE = 8'd10;
    localparam logic [7:0] TGA_BPP_24   = 8'd24;
    localparam logic [7:0] TGA_BPP_32   = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] RLE_RUN_FLAG = 8'h80;
    localparam logic [7:0] RLE_LEN_MASK = 8'h7f;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_IDSKIP,
        PH_PACKET,
        PH_PIXEL,
        PH_IDLE
    } front_phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_FIN
    } back_state_t;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_RUN,
        CMD_NOTE
    } cmd_op_t;

    // One command from front to back
    typedef struct packed {
        cmd_op_t     op;
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  count;
        logic [15:0] cols;
        logic [15:0] rows;
    } cmd_t;

    // One result beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] start_row;
        logic [15:0] start_column;
        logic [7:0]  pixel_count;
        logic        image_done;
    } res_t;

endpackage

### src/tga_rle_image_decoder.sv
`timescale 1ns / 1ps
// Path: a byte that ends a pixel goes through the command queue into the result
// register when the run stays in its row or crosses one row boundary; a run
// spanning more rows first goes through the 8-step back-end divider.
// Throughput: one byte per cycle while the command queue has room; a long run
// or a waiting result holds the back end, and a steady stream of them raises full.
// Reset: asynchronous, active low; the parser restarts at header byte 0.
// ----------------------------------------------------------------------------
// TGA truecolor RLE decoder
// Byte-stream TGA parser with a decoupled run placement back end.
// ----------------------------------------------------------------------------
module tga_rle_image_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        file_start,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic [15:0] start_row,
    output logic [15:0] start_column,
    output logic [7:0]  pixel_count,
    output logic        image_done
);
    import tgad_pkg::*;

    logic byte_take;
    logic cmd_push;
    cmd_t cmd_wr;
    logic q_full;
    logic q_empty;
    logic cmd_pop;
    cmd_t cmd_rd;
    logic res_valid;
    res_t res;

    assign byte_take = push && !q_full;
    assign full      = q_full;

    tgad_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_take  (byte_take),
        .data_byte  (data_byte),
        .file_start (file_start),
        .cmd_push   (cmd_push),
        .cmd        (cmd_wr)
    );

    tgad_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_wr),
        .full    (q_full),
        .pop     (cmd_pop),
        .rd_data (cmd_rd),
        .empty   (q_empty)
    );

    tgad_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (cmd_rd),
        .cmd_pop   (cmd_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    assign empty        = !res_valid;
    assign kind         = res.kind;
    assign red          = res.red;
    assign green        = res.green;
    assign blue         = res.blue;
    assign alpha        = res.alpha;
    assign start_row    = res.start_row;
    assign start_column = res.start_column;
    assign pixel_count  = res.pixel_count;
    assign image_done   = res.image_done;

endmodule

### src/tgad_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA decoder front end
// Parses header bytes and pixel packets, emits start, run and note commands.
// ----------------------------------------------------------------------------
module tgad_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_take,
    input  logic [7:0]     data_byte,
    input  logic           file_start,
    output logic           cmd_push,
    output tgad_pkg::cmd_t cmd
);
    import tgad_pkg::*;

    front_phase_t phase_reg, phase_next;
    logic [4:0]   hdr_idx_reg, hdr_idx_next;
    logic [7:0]   id_skip_reg, id_skip_next;
    logic [7:0]   low_hold_reg, low_hold_next;
    logic         rle_reg, rle_next;
    logic         bpp4_reg, bpp4_next;
    logic [15:0]  cols_reg, cols_next;
    logic [15:0]  rows_reg, rows_next;
    logic [7:0]   pkt_left_reg, pkt_left_next;
    logic         pkt_run_reg, pkt_run_next;
    logic [1:0]   cbi_reg, cbi_next;
    logic [31:0]  colour_reg, colour_next;
    logic         bad_type_reg, bad_type_next;
    logic         bad_fmt_reg, bad_fmt_next;

    // State as seen by this byte: a file start clears everything first
    front_phase_t cur_phase;
    logic [4:0]   cur_hdr_idx;
    logic [7:0]   cur_id_skip;
    logic [7:0]   cur_low_hold;
    logic         cur_rle;
    logic         cur_bpp4;
    logic [15:0]  cur_cols;
    logic [15:0]  cur_rows;
    logic [7:0]   cur_pkt_left;
    logic         cur_pkt_run;
    logic [1:0]   cur_cbi;
    logic [31:0]  cur_colour;
    logic         cur_bad_type;
    logic         cur_bad_fmt;

    logic [1:0]   last_cbi;
    logic         hdr_bad;
    logic         hdr_empty;
    logic         cmd_gen;
    logic [31:0]  colour_new;

    assign cur_phase    = file_start ? PH_HEADER : phase_reg;
    assign cur_hdr_idx  = file_start ? '0 : hdr_idx_reg;
    assign cur_id_skip  = file_start ? '0 : id_skip_reg;
    assign cur_low_hold = file_start ? '0 : low_hold_reg;
    assign cur_rle      = file_start ? 1'b0 : rle_reg;
    assign cur_bpp4     = file_start ? 1'b0 : bpp4_reg;
    assign cur_cols     = file_start ? '0 : cols_reg;
    assign cur_rows     = file_start ? '0 : rows_reg;
    assign cur_pkt_left = file_start ? '0 : pkt_left_reg;
    assign cur_pkt_run  = file_start ? 1'b0 : pkt_run_reg;
    assign cur_cbi      = file_start ? '0 : cbi_reg;
    assign cur_colour   = file_start ? '0 : colour_reg;
    assign cur_bad_type = file_start ? 1'b0 : bad_type_reg;
    assign cur_bad_fmt  = file_start ? 1'b0 : bad_fmt_reg;

    assign last_cbi  = cur_bpp4 ? 2'd3 : 2'd2;
    assign hdr_bad   = cur_bad_type || cur_bad_fmt;
    assign hdr_empty = (cur_cols == '0) || (cur_rows == '0);

    always_comb
    begin
        colour_new = (cur_cbi == 2'd0) ? '0 : cur_colour;
        colour_new[{cur_cbi, 3'b000} +: 8] = data_byte;
    end

    // Datapath and command generation
    always_comb
    begin
        hdr_idx_next  = cur_hdr_idx;
        id_skip_next  = cur_id_skip;
        low_hold_next = cur_low_hold;
        rle_next      = cur_rle;
        bpp4_next     = cur_bpp4;
        cols_next     = cur_cols;
        rows_next     = cur_rows;
        pkt_left_next = cur_pkt_left;
        pkt_run_next  = cur_pkt_run;
        cbi_next      = cur_cbi;
        colour_next   = cur_colour;
        bad_type_next = cur_bad_type;
        bad_fmt_next  = cur_bad_fmt;
        cmd_gen       = 1'b0;
        cmd           = '0;
        cmd.op        = CMD_RUN;

        case (cur_phase)
            PH_HEADER:
            begin
                case (cur_hdr_idx)
                    HDR_ID_LEN:    id_skip_next = data_byte;
                    HDR_CMAP_TYPE: if (data_byte != 8'd0) bad_fmt_next = 1'b1;
                    HDR_IMG_TYPE:
                    begin
                        bad_type_next = !(data_byte inside {TGA_TYPE_RAW, TGA_TYPE_RLE});
                        rle_next      = (data_byte == TGA_TYPE_RLE);
                    end
                    HDR_WIDTH_LO, HDR_HEIGHT_LO: low_hold_next = data_byte;
                    HDR_WIDTH_HI:  cols_next = {data_byte, cur_low_hold};
                    HDR_HEIGHT_HI: rows_next = {data_byte, cur_low_hold};
                    HDR_BPP:
                    begin
                        if (!(data_byte inside {TGA_BPP_24, TGA_BPP_32}))
                            bad_fmt_next = 1'b1;
                        bpp4_next = (data_byte == TGA_BPP_32);
                    end
                    default: ;
                endcase
                if (cur_hdr_idx != HDR_LAST)
                begin
                    hdr_idx_next = cur_hdr_idx + 5'd1;
                end
                else
                begin
                    cmd_gen = 1'b1;
                    if (hdr_bad)
                    begin
                        cmd.op   = CMD_NOTE;
                        cmd.kind = cur_bad_type ? KIND_BAD_TYPE : KIND_BAD_FMT;
                    end
                    else if (hdr_empty)
                    begin
                        cmd.op   = CMD_NOTE;
                        cmd.kind = KIND_EMPTY;
                    end
                    else
                    begin
                        cmd.op   = CMD_START;
                        cmd.cols = cur_cols;
                        cmd.rows = cur_rows;
                        cbi_next = '0;
                    end
                end
            end
            PH_IDSKIP:
            begin
                id_skip_next = cur_id_skip - 8'd1;
                cbi_next     = '0;
            end
            PH_PACKET:
            begin
                pkt_run_next  = (data_byte & RLE_RUN_FLAG) != 8'd0;
                pkt_left_next = (data_byte & RLE_LEN_MASK) + 8'd1;
                cbi_next      = '0;
            end
            PH_PIXEL:
            begin
                colour_next = colour_new;
                if (cur_cbi < last_cbi)
                begin
                    cbi_next = cur_cbi + 2'd1;
                end
                else
                begin
                    cbi_next   = '0;
                    cmd_gen    = 1'b1;
                    cmd.op     = CMD_RUN;
                    cmd.kind   = KIND_RUN;
                    cmd.blue   = colour_new[7:0];
                    cmd.green  = colour_new[15:8];
                    cmd.red    = colour_new[23:16];
                    cmd.alpha  = cur_bpp4 ? colour_new[31:24] : ALPHA_OPAQUE;
                    cmd.count  = (cur_rle && cur_pkt_run) ? cur_pkt_left : 8'd1;
                    if (cur_rle)
                        pkt_left_next = cur_pkt_run ? 8'd0 : cur_pkt_left - 8'd1;
                end
            end
            default: ;
        endcase
    end

    // Phase sequencing
    always_comb
    begin
        phase_next = cur_phase;
        case (cur_phase)
            PH_HEADER:
            begin
                if (cur_hdr_idx == HDR_LAST)
                begin
                    if (hdr_bad || hdr_empty)
                        phase_next = PH_IDLE;
                    else if (cur_id_skip != 8'd0)
                        phase_next = PH_IDSKIP;
                    else
                        phase_next = cur_rle ? PH_PACKET : PH_PIXEL;
                end
            end
            PH_IDSKIP:
            begin
                if (cur_id_skip == 8'd1)
                    phase_next = cur_rle ? PH_PACKET : PH_PIXEL;
            end
            PH_PACKET: phase_next = PH_PIXEL;
            PH_PIXEL:
            begin
                if (cur_cbi >= last_cbi && cur_rle && pkt_left_next == 8'd0)
                    phase_next = PH_PACKET;
            end
            PH_IDLE:   phase_next = PH_IDLE;
            default:   phase_next = PH_IDLE;
        endcase
    end

    assign cmd_push = byte_take && cmd_gen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            hdr_idx_reg  <= '0;
            id_skip_reg  <= '0;
            low_hold_reg <= '0;
            rle_reg      <= 1'b0;
            bpp4_reg     <= 1'b0;
            cols_reg     <= '0;
            rows_reg     <= '0;
            pkt_left_reg <= '0;
            pkt_run_reg  <= 1'b0;
            cbi_reg      <= '0;
            colour_reg   <= '0;
            bad_type_reg <= 1'b0;
            bad_fmt_reg  <= 1'b0;
        end
        else if (byte_take)
        begin
            phase_reg    <= phase_next;
            hdr_idx_reg  <= hdr_idx_next;
            id_skip_reg  <= id_skip_next;
            low_hold_reg <= low_hold_next;
            rle_reg      <= rle_next;
            bpp4_reg     <= bpp4_next;
            cols_reg     <= cols_next;
            rows_reg     <= rows_next;
            pkt_left_reg <= pkt_left_next;
            pkt_run_reg  <= pkt_run_next;
            cbi_reg      <= cbi_next;
            colour_reg   <= colour_next;
            bad_type_reg <= bad_type_next;
            bad_fmt_reg  <= bad_fmt_next;
        end
    end

endmodule

### src/tgad_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA decoder command queue
// Short register queue that decouples the front parser from the back end.
// ----------------------------------------------------------------------------
module tgad_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tgad_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           pop,
    output tgad_pkg::cmd_t rd_data,
    output logic           empty
);
    import tgad_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("command popped from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");

endmodule

### src/tgad_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA decoder back end
// Places runs in the image, clips at the end and drives the result register.
// ----------------------------------------------------------------------------
module tgad_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  tgad_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           res_valid,
    output tgad_pkg::res_t res,
    input  logic           res_pop
);
    import tgad_pkg::*;

    back_state_t state_reg, state_next;
    logic        finished_reg, finished_next;
    logic [2:0]  div_cnt_reg, div_cnt_next;
    logic        res_valid_reg, res_valid_next;

    logic [15:0] cols_reg, cols_next;
    logic [15:0] row_reg, row_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  quo_reg, quo_next;
    logic [7:0]  run_n_reg, run_n_next;
    logic [7:0]  run_red_reg, run_red_next;
    logic [7:0]  run_green_reg, run_green_next;
    logic [7:0]  run_blue_reg, run_blue_next;
    logic [7:0]  run_alpha_reg, run_alpha_next;
    res_t        res_reg;

    logic        out_free;
    logic        res_load;
    res_t        res_new;

    // Fast path: run stays in this row or crosses one row boundary
    logic [16:0] pos;
    logic [16:0] cols17;
    logic        pos_lt1;
    logic        pos_lt2;
    logic [16:0] pos_wrap;
    logic        fast_done;
    logic [15:0] fast_span;
    logic [7:0]  fast_count;

    // Divider step
    logic [16:0] div_trial;
    logic        div_fit;
    logic [16:0] div_diff;

    // Finish of a long run
    logic        fin_done;
    logic [8:0]  row_p1;
    logic [24:0] prod;
    logic [24:0] clip;
    logic [7:0]  fin_count;

    assign out_free = !res_valid_reg || res_pop;

    assign cols17    = {1'b0, cols_reg};
    assign pos       = {1'b0, col_reg} + {9'd0, cmd.count};
    assign pos_lt1   = pos < cols17;
    assign pos_lt2   = pos < {cols_reg, 1'b0};
    assign pos_wrap  = pos - cols17;
    assign fast_done = !pos_lt1 && (row_reg == '0);
    assign fast_span = cols_reg - col_reg;
    assign fast_count = fast_done ? fast_span[7:0] : cmd.count;

    assign div_trial = {rem_reg, quo_reg[7]};
    assign div_fit   = div_trial >= cols17;
    assign div_diff  = div_trial - cols17;

    assign fin_done  = {8'd0, quo_reg} > row_reg;
    assign row_p1    = {1'b0, row_reg[7:0]} + 9'd1;
    assign prod      = row_p1 * cols_reg;
    assign clip      = prod - {9'd0, col_reg};
    assign fin_count = fin_done ? clip[7:0] : run_n_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && cmd.op == CMD_RUN && !finished_reg && !pos_lt2)
                    state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (div_cnt_reg == 3'd7)
                    state_next = BK_FIN;
            end
            BK_FIN:
            begin
                if (out_free)
                    state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        cmd_pop        = 1'b0;
        res_load       = 1'b0;
        res_new        = '0;
        finished_next  = finished_reg;
        div_cnt_next   = div_cnt_reg;
        cols_next      = cols_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        run_n_next     = run_n_reg;
        run_red_next   = run_red_reg;
        run_green_next = run_green_reg;
        run_blue_next  = run_blue_reg;
        run_alpha_next = run_alpha_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        CMD_START:
                        begin
                            cmd_pop       = 1'b1;
                            cols_next     = cmd.cols;
                            row_next      = cmd.rows - 16'd1;
                            col_next      = '0;
                            finished_next = 1'b0;
                        end
                        CMD_NOTE:
                        begin
                            if (out_free)
                            begin
                                cmd_pop            = 1'b1;
                                res_load           = 1'b1;
                                res_new.kind       = cmd.kind;
                                res_new.image_done = (cmd.kind == KIND_EMPTY);
                            end
                        end
                        CMD_RUN:
                        begin
                            if (finished_reg)
                            begin
                                // drop runs past the end of the image
                                cmd_pop = 1'b1;
                            end
                            else if (pos_lt2)
                            begin
                                if (out_free)
                                begin
                                    cmd_pop              = 1'b1;
                                    res_load             = 1'b1;
                                    res_new.kind         = KIND_RUN;
                                    res_new.red          = cmd.red;
                                    res_new.green        = cmd.green;
                                    res_new.blue         = cmd.blue;
                                    res_new.alpha        = cmd.alpha;
                                    res_new.start_row    = row_reg;
                                    res_new.start_column = col_reg;
                                    res_new.pixel_count  = fast_count;
                                    res_new.image_done   = fast_done;
                                    if (fast_done)
                                    begin
                                        finished_next = 1'b1;
                                    end
                                    else if (pos_lt1)
                                    begin
                                        col_next = pos[15:0];
                                    end
                                    else
                                    begin
                                        row_next = row_reg - 16'd1;
                                        col_next = pos_wrap[15:0];
                                    end
                                end
                            end
                            else
                            begin
                                // long run: load the divider with column plus count
                                cmd_pop        = 1'b1;
                                rem_next       = {7'd0, pos[16:8]};
                                quo_next       = pos[7:0];
                                div_cnt_next   = '0;
                                run_n_next     = cmd.count;
                                run_red_next   = cmd.red;
                                run_green_next = cmd.green;
                                run_blue_next  = cmd.blue;
                                run_alpha_next = cmd.alpha;
                            end
                        end
                        default: cmd_pop = 1'b1;
                    endcase
                end
            end
            BK_DIV:
            begin
                rem_next     = div_fit ? div_diff[15:0] : div_trial[15:0];
                quo_next     = {quo_reg[6:0], div_fit};
                div_cnt_next = div_cnt_reg + 3'd1;
            end
            BK_FIN:
            begin
                if (out_free)
                begin
                    res_load             = 1'b1;
                    res_new.kind         = KIND_RUN;
                    res_new.red          = run_red_reg;
                    res_new.green        = run_green_reg;
                    res_new.blue         = run_blue_reg;
                    res_new.alpha        = run_alpha_reg;
                    res_new.start_row    = row_reg;
                    res_new.start_column = col_reg;
                    res_new.pixel_count  = fin_count;
                    res_new.image_done   = fin_done;
                    if (fin_done)
                    begin
                        finished_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg - {8'd0, quo_reg};
                        col_next = rem_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
            res_valid_next = 1'b1;
        else if (res_pop)
            res_valid_next = 1'b0;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            finished_reg  <= 1'b1;
            div_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            finished_reg  <= finished_next;
            div_cnt_reg   <= div_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cols_reg      <= cols_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        run_n_reg     <= run_n_next;
        run_red_reg   <= run_red_next;
        run_green_reg <= run_green_next;
        run_blue_reg  <= run_blue_next;
        run_alpha_reg <= run_alpha_next;
        if (res_load)
            res_reg <= res_new;
    end

    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res_new.kind == KIND_RUN) |->
            (res_new.pixel_count != 8'd0 && res_new.pixel_count <= 8'd128))
        else $error("run result with bad pixel count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res_valid_reg) |-> res_pop)
        else $error("result register overwritten before it was taken");

    a_no_run_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> !(res_load && res_new.kind == KIND_RUN))
        else $error("run result after image completion");

    a_column_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res_new.kind == KIND_RUN && !res_new.image_done) |=>
            col_reg < cols_reg)
        else $error("column left the row after a run");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV) |-> (cols_reg != '0 && !finished_reg))
        else $error("divider running without an open image");

endmodule

### bench/tga_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA decoder result checker
// Watches the byte and result channels of the decoder, decodes every accepted
// byte with its own copy of the parser state, and compares each popped result
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tga_decoder_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  data_byte,
    input  logic        file_start,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  kind,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  alpha,
    input  logic [15:0] start_row,
    input  logic [15:0] start_column,
    input  logic [7:0]  pixel_count,
    input  logic        image_done,
    output int          mismatches,
    output int          results_due
);
    import tgad_pkg::*;

    // Parser state as the decoder should hold it
    front_phase_t ph;
    logic [4:0]   hdr_idx;
    logic [7:0]   id_left;
    logic [7:0]   lo_hold;
    logic         rle;
    logic         bpp32;
    logic [15:0]  cols;
    logic [15:0]  rows;
    logic [15:0]  row;
    logic [15:0]  col;
    logic [7:0]   pkt_left;
    logic         pkt_run;
    logic [1:0]   cbyte;
    logic [31:0]  colour;
    logic         type_bad;
    logic         fmt_bad;

    res_t predicted_results[$];
    res_t want_run;

    task automatic clear_parser();
        ph       = PH_HEADER;
        hdr_idx  = '0;
        id_left  = '0;
        lo_hold  = '0;
        rle      = 1'b0;
        bpp32    = 1'b0;
        cols     = '0;
        rows     = '0;
        row      = '0;
        col      = '0;
        pkt_left = '0;
        pkt_run  = 1'b0;
        cbyte    = '0;
        colour   = '0;
        type_bad = 1'b0;
        fmt_bad  = 1'b0;
    endtask

    task automatic enter_pixel_data();
        ph    = rle ? PH_PACKET : PH_PIXEL;
        cbyte = '0;
    endtask

    // Place a run of n pixels at the current position, clipped to the image end
    task automatic place_run(input logic [31:0] n);
        logic [31:0] remain;
        logic [31:0] pos;
        logic [31:0] adv;
        logic [31:0] wide_cols;
        res_t        r;
        wide_cols = {16'd0, cols};
        remain = {16'd0, row} * wide_cols + wide_cols - {16'd0, col};
        if (n > remain)
            n = remain;
        r              = '0;
        r.kind         = KIND_RUN;
        r.red          = colour[23:16];
        r.green        = colour[15:8];
        r.blue         = colour[7:0];
        r.alpha        = bpp32 ? colour[31:24] : ALPHA_OPAQUE;
        r.start_row    = row;
        r.start_column = col;
        r.pixel_count  = n[7:0];
        pos = {16'd0, col} + n;
        adv = pos / wide_cols;
        r.image_done = (adv > {16'd0, row});
        if (r.image_done)
            ph = PH_IDLE;
        else
        begin
            row = row - adv[15:0];
            pos = pos % wide_cols;
            col = pos[15:0];
        end
        predicted_results.push_back(r);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic fs);
        logic [1:0] last_byte;
        res_t       r;
        if (fs)
            clear_parser();
        case (ph)
            PH_HEADER:
            begin
                case (hdr_idx)
                    HDR_ID_LEN:    id_left = b;
                    HDR_CMAP_TYPE: if (b != 8'd0) fmt_bad = 1'b1;
                    HDR_IMG_TYPE:
                    begin
                        type_bad = (b != TGA_TYPE_RAW) && (b != TGA_TYPE_RLE);
                        rle      = (b == TGA_TYPE_RLE);
                    end
                    HDR_WIDTH_LO, HDR_HEIGHT_LO: lo_hold = b;
                    HDR_WIDTH_HI:  cols = {b, lo_hold};
                    HDR_HEIGHT_HI: rows = {b, lo_hold};
                    HDR_BPP:
                    begin
                        if (b != TGA_BPP_24 && b != TGA_BPP_32)
                            fmt_bad = 1'b1;
                        bpp32 = (b == TGA_BPP_32);
                    end
                    default: ;
                endcase
                r = '0;
                if (hdr_idx != HDR_LAST)
                    hdr_idx++;
                else if (type_bad || fmt_bad)
                begin
                    r.kind = type_bad ? KIND_BAD_TYPE : KIND_BAD_FMT;
                    predicted_results.push_back(r);
                    ph = PH_IDLE;
                end
                else if (cols == 16'd0 || rows == 16'd0)
                begin
                    r.kind       = KIND_EMPTY;
                    r.image_done = 1'b1;
                    predicted_results.push_back(r);
                    ph = PH_IDLE;
                end
                else
                begin
                    // Bottom row first
                    row = rows - 16'd1;
                    col = '0;
                    if (id_left != 8'd0)
                        ph = PH_IDSKIP;
                    else
                        enter_pixel_data();
                end
            end
            PH_IDSKIP:
            begin
                id_left--;
                if (id_left == 8'd0)
                    enter_pixel_data();
            end
            PH_PACKET:
            begin
                pkt_run  = (b & RLE_RUN_FLAG) != 8'd0;
                pkt_left = (b & RLE_LEN_MASK) + 8'd1;
                cbyte    = '0;
                ph       = PH_PIXEL;
            end
            PH_PIXEL:
            begin
                if (cbyte == 2'd0)
                    colour = '0;
                colour    = colour | ({24'd0, b} << (8 * cbyte));
                last_byte = bpp32 ? 2'd3 : 2'd2;
                if (cbyte < last_byte)
                    cbyte++;
                else
                begin
                    cbyte = '0;
                    if (!rle)
                        place_run(32'd1);
                    else if (pkt_run)
                    begin
                        place_run({24'd0, pkt_left});
                        pkt_left = '0;
                    end
                    else
                    begin
                        place_run(32'd1);
                        pkt_left--;
                    end
                    if (ph != PH_IDLE && rle && pkt_left == 8'd0)
                        ph = PH_PACKET;
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            predicted_results.delete();
        end
        else
        begin
            if (push && !full)
                decode_byte(data_byte, file_start);
            if (pop && !empty)
            begin
                if (predicted_results.size() == 0)
                    report_mismatch("result beat with no result predicted");
                else
                begin
                    want_run = predicted_results.pop_front();
                    check_field("kind", 16'(kind), 16'(want_run.kind));
                    check_field("red", 16'(red), 16'(want_run.red));
                    check_field("green", 16'(green), 16'(want_run.green));
                    check_field("blue", 16'(blue), 16'(want_run.blue));
                    check_field("alpha", 16'(alpha), 16'(want_run.alpha));
                    check_field("start_row", start_row, want_run.start_row);
                    check_field("start_column", start_column, want_run.start_column);
                    check_field("pixel_count", 16'(pixel_count),
                                16'(want_run.pixel_count));
                    check_field("image_done", 16'(image_done),
                                16'(want_run.image_done));
                end
            end
        end
        results_due = predicted_results.size();
    end

endmodule

### bench/tb_tga_rle_image_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE image decoder testbench
// Streams directed and random TGA files (good, truncated, empty, bad headers
// and noise) into the decoder with random push and pop gaps; the checker
// predicts every run and counts mismatches.
// ----------------------------------------------------------------------------
module tb_tga_rle_image_decoder;
    import tgad_pkg::*;

    localparam int BYTE_TARGET = 600;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        push       = 1'b0;
    logic [7:0]  data_byte  = 8'd0;
    logic        file_start = 1'b0;
    logic        pop        = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] start_row;
    logic [15:0] start_column;
    logic [7:0]  pixel_count;
    logic        image_done;

    int send_idle_pct = 21;
    int recv_idle_pct = 49;
    int fed_bytes     = 0;
    int mismatches;
    int results_due;

    tga_rle_image_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .file_start   (file_start),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .start_row    (start_row),
        .start_column (start_column),
        .pixel_count  (pixel_count),
        .image_done   (image_done)
    );

    tga_decoder_checker decode_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .file_start   (file_start),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .start_row    (start_row),
        .start_column (start_column),
        .pixel_count  (pixel_count),
        .image_done   (image_done),
        .mismatches   (mismatches),
        .results_due  (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL tga_rle_image_decoder");
        $finish;
    end

    always @(negedge clk)
        pop <= ($urandom_range(99) >= recv_idle_pct);

    // Called at a falling edge; returns at the falling edge after the beat
    task automatic send_byte(input logic [7:0] b, input logic fs, input bit live);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        data_byte  <= b;
        file_start <= fs;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        if (live)
            fed_bytes++;
    endtask

    task automatic send_colour(input bit wide);
        repeat (wide ? 4 : 3)
            send_byte(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // Send a header, ID field, pixel data for up to max_pixels, then stray bytes
    task automatic send_file(input logic fs, input logic [7:0] id_len,
                             input logic [7:0] cmap, input logic [7:0] itype,
                             input logic [15:0] cols, input logic [15:0] rows,
                             input logic [7:0] bpp, input int max_pixels,
                             input bit long_runs);
        logic [7:0] hdr [18];
        logic [6:0] len_code;
        longint     pix_left;
        int         len;
        bit         run;
        bit         good;
        bit         wide;
        foreach (hdr[i])
            hdr[i] = 8'($urandom_range(255));
        hdr[HDR_ID_LEN]    = id_len;
        hdr[HDR_CMAP_TYPE] = cmap;
        hdr[HDR_IMG_TYPE]  = itype;
        hdr[HDR_WIDTH_LO]  = cols[7:0];
        hdr[HDR_WIDTH_HI]  = cols[15:8];
        hdr[HDR_HEIGHT_LO] = rows[7:0];
        hdr[HDR_HEIGHT_HI] = rows[15:8];
        hdr[HDR_BPP]       = bpp;
        foreach (hdr[i])
            send_byte(hdr[i], (i == 0) ? fs : 1'b0, 1'b1);
        good = (itype == TGA_TYPE_RAW || itype == TGA_TYPE_RLE) && cmap == 8'd0
            && (bpp == TGA_BPP_24 || bpp == TGA_BPP_32)
            && cols != 16'd0 && rows != 16'd0;
        wide = (bpp == TGA_BPP_32);
        if (good)
        begin
            repeat (id_len)
                send_byte(8'($urandom_range(255)), 1'b0, 1'b1);
            pix_left = longint'(cols);
            pix_left = pix_left * rows;
            if (pix_left > max_pixels)
                pix_left = longint'(max_pixels);
            while (pix_left > 0)
            begin
                if (itype == TGA_TYPE_RAW)
                begin
                    send_colour(wide);
                    len = 1;
                end
                else
                begin
                    run = long_runs || ($urandom_range(1) == 1);
                    if (long_runs)
                        len = 128;
                    else if (run && $urandom_range(3) == 0)
                        len = $urandom_range(1, 128);
                    else
                        len = $urandom_range(1, 4);
                    len_code = 7'(len - 1);
                    send_byte({run, len_code}, 1'b0, 1'b1);
                    if (run)
                        send_colour(wide);
                    else
                        repeat (len)
                            send_colour(wide);
                end
                pix_left -= len;
            end
        end
        // Trailing bytes past the image or an error are dropped by the block
        repeat ($urandom_range(2))
            send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    endtask

    initial
    begin
        int         sel;
        int         shape;
        int         max_pixels;
        bit         long_runs;
        logic [7:0] itype;
        logic [7:0] bpp;
        logic [7:0] cmap;
        logic [7:0] id_len;
        logic [15:0] cols;
        logic [15:0] rows;

        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;

        // First file without a file start marker, with an ID field
        send_file(1'b0, 8'd1, 8'd0, TGA_TYPE_RAW, 16'd2, 16'd1, TGA_BPP_24, 2, 1'b0);
        // Bad type, bad type with bad colour map, bad colour map, bad pixel size
        send_file(1'b1, 8'd0, 8'd0, 8'd3, 16'd4, 16'd4, TGA_BPP_24, 0, 1'b0);
        send_file(1'b1, 8'd0, 8'd1, 8'd1, 16'd4, 16'd4, 8'd16, 0, 1'b0);
        send_file(1'b1, 8'd0, 8'd1, TGA_TYPE_RAW, 16'd2, 16'd2, TGA_BPP_32, 4, 1'b0);
        send_file(1'b1, 8'd0, 8'd0, TGA_TYPE_RLE, 16'd2, 16'd2, 8'd16, 4, 1'b0);
        // Empty images
        send_file(1'b1, 8'd2, 8'd0, TGA_TYPE_RLE, 16'd0, 16'd5, TGA_BPP_24, 4, 1'b0);
        send_file(1'b1, 8'd0, 8'd0, TGA_TYPE_RAW, 16'd3, 16'd0, TGA_BPP_32, 4, 1'b0);
        // Full-length runs clipped at the image end, and runs over many rows
        send_file(1'b1, 8'd0, 8'd0, TGA_TYPE_RLE, 16'd3, 16'd2, TGA_BPP_32, 6, 1'b1);
        send_file(1'b1, 8'd0, 8'd0, TGA_TYPE_RLE, 16'd1, 16'd60, TGA_BPP_24, 60, 1'b1);
        // Largest image, cut short by the next file
        send_file(1'b1, 8'd3, 8'd0, TGA_TYPE_RAW, 16'hffff, 16'hffff, TGA_BPP_32, 3, 1'b0);

        while (fed_bytes < BYTE_TARGET)
        begin
            if (fed_bytes >= 425)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (fed_bytes >= 250)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 21;
            end
            sel        = $urandom_range(99);
            shape      = $urandom_range(9);
            itype      = $urandom_range(1) ? TGA_TYPE_RLE : TGA_TYPE_RAW;
            bpp        = $urandom_range(1) ? TGA_BPP_32 : TGA_BPP_24;
            cmap       = 8'd0;
            id_len     = 8'(($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0);
            cols       = 16'($urandom_range(1, 8));
            rows       = 16'($urandom_range(1, 5));
            max_pixels = ($urandom_range(4) == 0) ? $urandom_range(0, 8) : 48;
            long_runs  = 1'b0;
            if (sel < 60)
            begin
                if (shape == 0)
                begin
                    // Narrow and tall: runs wrap over many rows
                    cols = 16'($urandom_range(1, 3));
                    rows = 16'($urandom_range(10, 80));
                    if (itype == TGA_TYPE_RLE && $urandom_range(1) == 1)
                    begin
                        long_runs  = 1'b1;
                        max_pixels = 240;
                    end
                end
                else if (shape == 1)
                begin
                    cols       = 16'($urandom_range(16'hffff));
                    rows       = 16'($urandom_range(16'hffff));
                    max_pixels = $urandom_range(1, 12);
                end
                send_file(1'b1, id_len, cmap, itype, cols, rows, bpp, max_pixels,
                          long_runs);
            end
            else if (sel < 70)
            begin
                if ($urandom_range(1))
                    cols = 16'd0;
                else
                    rows = 16'd0;
                send_file(1'b1, id_len, cmap, itype, cols, rows, bpp, max_pixels, 1'b0);
            end
            else if (sel < 85)
            begin
                itype = ($urandom_range(2) == 0) ? itype : 8'($urandom_range(255));
                cmap  = 8'(($urandom_range(3) == 0) ? $urandom_range(1, 255) : 0);
                bpp   = ($urandom_range(2) == 0) ? 8'($urandom_range(255)) : bpp;
                send_file(1'b1, id_len, cmap, itype, cols, rows, bpp, max_pixels, 1'b0);
            end
            else
            begin
                // Noise with stray restarts
                send_byte(8'($urandom_range(255)), 1'b1, 1'b1);
                repeat ($urandom_range(15))
                    send_byte(8'($urandom_range(255)), ($urandom_range(19) == 0), 1'b1);
            end
        end

        push <= 1'b0;
        recv_idle_pct = 0;
        while (results_due != 0)
            @(negedge clk);
        // Allow the back-end divider to drain anything unpredicted
        repeat (30)
            @(negedge clk);
        if (mismatches == 0)
            $display("PASS tga_rle_image_decoder");
        else
            $display("FAIL tga_rle_image_decoder");
        $finish;
    end

endmodule
